[src/lpl2x2_pkg.sv]
// ----------------------------------------------------------------------------
// lpl2x2_pkg: shared types and constants
// Field widths, register map and reset values for the 2x2 box pyramid level.
// ----------------------------------------------------------------------------
package lpl2x2_pkg;

   // default sizing of the top level
   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 4096;
   localparam int PIXEL_BITS_DEF = 16;

   // fixed field widths
   localparam int PIXEL_W   = 16;
   localparam int MEAN_W    = 18;
   localparam int DETAIL_W  = 19;
   localparam int BCOL_W    = 10;
   localparam int BROW_W    = 11;
   localparam int FW_W      = 12;
   localparam int FH_W      = 13;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [FW_W-1:0] RESET_FRAME_WIDTH  = 12'd2048;
   localparam logic [FH_W-1:0] RESET_FRAME_HEIGHT = 13'd2048;

   // register index (byte address bit 2)
   typedef enum logic [0:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   // current frame geometry
   typedef struct packed {
      logic [FW_W-1:0] frame_width;
      logic [FH_W-1:0] frame_height;
   } cfg_type;

endpackage

[src/laplacian_level_2x2_box.sv]
// ----------------------------------------------------------------------------
// laplacian_level_2x2_box: one Laplacian pyramid level with a 2x2 box filter
// Raster pixels in, one block sum and four detail values per 2x2 block out.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock while rsp_ready stays high. While a finished result
// waits on rsp_ready, pixels are still taken until a second finished block fills
// stage 1; then req_ready drops until the result is taken. Pixels of even rows go
// into a MAX_WIDTH-deep line store. On the second pixel of each block in an odd
// row, the two top pixels are read from the store (two read ports). The result
// reaches rsp_* through stage 1 and the result register. The store read data is
// registered when that pixel is accepted, together with the bottom pair. The sum
// and detail adders load the result register as stage 1 advances. Odd trailing
// rows and columns are consumed without a result. frame_start on a pixel puts it
// at column 0, row 0. The line store has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module laplacian_level_2x2_box #(
   parameter int MAX_WIDTH  = lpl2x2_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lpl2x2_pkg::MAX_HEIGHT_DEF,
   parameter int PIXEL_BITS = lpl2x2_pkg::PIXEL_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // pixel requests
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [lpl2x2_pkg::PIXEL_W-1:0]           req_pixel,
   input  logic                                     req_frame_start,
   // block results
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [lpl2x2_pkg::MEAN_W-1:0]            rsp_mean_quarters,
   output logic signed [lpl2x2_pkg::DETAIL_W-1:0]   rsp_detail_top_left,
   output logic signed [lpl2x2_pkg::DETAIL_W-1:0]   rsp_detail_top_right,
   output logic signed [lpl2x2_pkg::DETAIL_W-1:0]   rsp_detail_bottom_left,
   output logic signed [lpl2x2_pkg::DETAIL_W-1:0]   rsp_detail_bottom_right,
   output logic [lpl2x2_pkg::BCOL_W-1:0]            rsp_block_column,
   output logic [lpl2x2_pkg::BROW_W-1:0]            rsp_block_row,
   output logic                                     rsp_last_block,
   // configuration
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [lpl2x2_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [lpl2x2_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [lpl2x2_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                     csr_pready
);

   localparam int STORE_BITS = (PIXEL_BITS < lpl2x2_pkg::PIXEL_W) ?
                               PIXEL_BITS : lpl2x2_pkg::PIXEL_W;
   localparam int ADDR_BITS  = $clog2(MAX_WIDTH);
   localparam int LEN_W_BITS = $clog2(MAX_WIDTH + 1);
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
   localparam int LEN_H_BITS = $clog2(MAX_HEIGHT + 1);
   localparam int WCMP_BITS  = (lpl2x2_pkg::FW_W > LEN_W_BITS) ?
                               lpl2x2_pkg::FW_W : LEN_W_BITS;
   localparam int HCMP_BITS  = (lpl2x2_pkg::FH_W > LEN_H_BITS) ?
                               lpl2x2_pkg::FH_W : LEN_H_BITS;
   localparam int MEAN_W     = lpl2x2_pkg::MEAN_W;
   localparam int DETAIL_W   = lpl2x2_pkg::DETAIL_W;

   lpl2x2_pkg::cfg_type cfg;

   // position and per-pixel decode
   logic [ADDR_BITS-1:0]  col_ff, col_in, col_cur;
   logic [ROW_BITS-1:0]   row_ff, row_in, row_cur;
   logic [WCMP_BITS-1:0]  fw_ext;
   logic [HCMP_BITS-1:0]  fh_ext;
   logic [LEN_W_BITS-1:0] row_len, even_w, col_next;
   logic [LEN_H_BITS-1:0] col_len, even_h, row_next;
   logic                  in_frame, blk_emit, store_wr, left_capture, blk_last;
   logic                  req_accept;
   logic [STORE_BITS-1:0] pix;
   logic [STORE_BITS-1:0] left_pixel_ff;

   // stage 1: block gathered, top pixels arriving from the store
   logic                          s1_valid_ff, s1_valid_in, s1_advance;
   logic [STORE_BITS-1:0]         s1_left_ff, s1_right_ff;
   logic [lpl2x2_pkg::BCOL_W-1:0] s1_col_ff;
   logic [lpl2x2_pkg::BROW_W-1:0] s1_row_ff;
   logic                          s1_last_ff;
   logic [STORE_BITS-1:0]         top_left, top_right;

   // stage 2: result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [MEAN_W-1:0]             blk_sum;
   logic [DETAIL_W-1:0]           d_tl, d_tr, d_bl, d_br;
   logic [MEAN_W-1:0]             out_mean_ff;
   logic [DETAIL_W-1:0]           out_tl_ff, out_tr_ff, out_bl_ff, out_br_ff;
   logic [lpl2x2_pkg::BCOL_W-1:0] out_col_ff;
   logic [lpl2x2_pkg::BROW_W-1:0] out_row_ff;
   logic                          out_last_ff;

   lpl2x2_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // clamp the frame geometry to 1..max and take the even part
   always_comb begin
      fw_ext = WCMP_BITS'(cfg.frame_width);
      fh_ext = HCMP_BITS'(cfg.frame_height);
      if (fw_ext == '0) begin
         row_len = LEN_W_BITS'(1);
      end else if (fw_ext > WCMP_BITS'(MAX_WIDTH)) begin
         row_len = LEN_W_BITS'(MAX_WIDTH);
      end else begin
         row_len = LEN_W_BITS'(fw_ext);
      end
      if (fh_ext == '0) begin
         col_len = LEN_H_BITS'(1);
      end else if (fh_ext > HCMP_BITS'(MAX_HEIGHT)) begin
         col_len = LEN_H_BITS'(MAX_HEIGHT);
      end else begin
         col_len = LEN_H_BITS'(fh_ext);
      end
      even_w = {row_len[LEN_W_BITS-1:1], 1'b0};
      even_h = {col_len[LEN_H_BITS-1:1], 1'b0};
   end

   // decode of the incoming pixel's position
   always_comb begin
      col_cur      = req_frame_start ? '0 : col_ff;
      row_cur      = req_frame_start ? '0 : row_ff;
      pix          = req_pixel[STORE_BITS-1:0];
      in_frame     = (LEN_W_BITS'(col_cur) < even_w) && (LEN_H_BITS'(row_cur) < even_h);
      store_wr     = in_frame && !row_cur[0];
      left_capture = in_frame && row_cur[0] && !col_cur[0];
      blk_emit     = in_frame && row_cur[0] && col_cur[0];
      blk_last     = (LEN_W_BITS'(col_cur) == LEN_W_BITS'(even_w - 1'b1)) &&
                     (LEN_H_BITS'(row_cur) == LEN_H_BITS'(even_h - 1'b1));
   end

   // position advance with row and frame wrap
   always_comb begin
      col_next = LEN_W_BITS'(col_cur) + LEN_W_BITS'(1);
      row_next = LEN_H_BITS'(row_cur) + LEN_H_BITS'(1);
      col_in   = ADDR_BITS'(col_next);
      row_in   = row_cur;
      if (col_next >= row_len) begin
         col_in = '0;
         row_in = (row_next >= col_len) ? '0 : ROW_BITS'(row_next);
      end
   end

   // handshake
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept && blk_emit) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         left_pixel_ff <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
            if (left_capture) begin
               left_pixel_ff <= pix;
            end
         end
      end
   end

   // line store: even rows written, top pair read on the block's second pixel
   lpl2x2_line_store #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (STORE_BITS)
   ) u_line_store (
      .clock     (clock),
      .wr_en     (req_accept && store_wr),
      .wr_addr   (col_cur),
      .wr_data   (pix),
      .rd_en     (req_accept && blk_emit),
      .rd_addr_a (col_cur - ADDR_BITS'(1)),
      .rd_addr_b (col_cur),
      .rd_data_a (top_left),
      .rd_data_b (top_right)
   );

   // stage 1 payload
   always_ff @(posedge clock) begin
      if (req_accept && blk_emit) begin
         s1_left_ff  <= left_pixel_ff;
         s1_right_ff <= pix;
         s1_col_ff   <= lpl2x2_pkg::BCOL_W'(col_cur >> 1);
         s1_row_ff   <= lpl2x2_pkg::BROW_W'(row_cur >> 1);
         s1_last_ff  <= blk_last;
      end
   end

   // block sum and detail values (4*pixel - sum)
   always_comb begin
      blk_sum = MEAN_W'(top_left) + MEAN_W'(top_right) +
                MEAN_W'(s1_left_ff) + MEAN_W'(s1_right_ff);
      d_tl = (DETAIL_W'(top_left) << 2)    - DETAIL_W'(blk_sum);
      d_tr = (DETAIL_W'(top_right) << 2)   - DETAIL_W'(blk_sum);
      d_bl = (DETAIL_W'(s1_left_ff) << 2)  - DETAIL_W'(blk_sum);
      d_br = (DETAIL_W'(s1_right_ff) << 2) - DETAIL_W'(blk_sum);
   end

   // result register
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_mean_ff <= blk_sum;
         out_tl_ff   <= d_tl;
         out_tr_ff   <= d_tr;
         out_bl_ff   <= d_bl;
         out_br_ff   <= d_br;
         out_col_ff  <= s1_col_ff;
         out_row_ff  <= s1_row_ff;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_mean_quarters       = out_mean_ff;
   assign rsp_detail_top_left     = signed'(out_tl_ff);
   assign rsp_detail_top_right    = signed'(out_tr_ff);
   assign rsp_detail_bottom_left  = signed'(out_bl_ff);
   assign rsp_detail_bottom_right = signed'(out_br_ff);
   assign rsp_block_column        = out_col_ff;
   assign rsp_block_row           = out_row_ff;
   assign rsp_last_block          = out_last_ff;

`ifndef SYNTHESIS
   // a full stage 1 behind a stalled result must hold off new requests
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request accepted while both stages are stalled");

   // the second pixel of a block fills stage 1
   a_emit_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_accept && blk_emit) |=> s1_valid_ff)
      else $error("block pixel accepted but stage 1 not loaded");

   // a result only appears after stage 1 held a block
   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result raised without a block in stage 1");

   // the four details always cancel out
   a_detail_sum_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (DETAIL_W'(out_tl_ff + out_tr_ff + out_bl_ff + out_br_ff) == '0))
      else $error("detail values do not sum to zero");
`endif

endmodule

[src/lpl2x2_csr.sv]
// ----------------------------------------------------------------------------
// lpl2x2_csr: configuration registers
// APB-style register file holding frame width and frame height.
// ----------------------------------------------------------------------------
module lpl2x2_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lpl2x2_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [lpl2x2_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [lpl2x2_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                pready,
   output lpl2x2_pkg::cfg_type                 cfg
);

   lpl2x2_pkg::cfg_type       cfg_ff;
   lpl2x2_pkg::reg_index_type reg_index;
   logic                      write_en;

   assign pready    = 1'b1;
   assign reg_index = lpl2x2_pkg::reg_index_type'(paddr[2]);
   assign write_en  = psel && penable && pwrite;
   assign cfg       = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= lpl2x2_pkg::RESET_FRAME_WIDTH;
         cfg_ff.frame_height <= lpl2x2_pkg::RESET_FRAME_HEIGHT;
      end else if (write_en) begin
         unique case (reg_index)
            lpl2x2_pkg::REG_FRAME_WIDTH: begin
               cfg_ff.frame_width <= pwdata[lpl2x2_pkg::FW_W-1:0];
            end
            lpl2x2_pkg::REG_FRAME_HEIGHT: begin
               cfg_ff.frame_height <= pwdata[lpl2x2_pkg::FH_W-1:0];
            end
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_index)
         lpl2x2_pkg::REG_FRAME_WIDTH: begin
            prdata = lpl2x2_pkg::CSR_DATA_W'(cfg_ff.frame_width);
         end
         lpl2x2_pkg::REG_FRAME_HEIGHT: begin
            prdata = lpl2x2_pkg::CSR_DATA_W'(cfg_ff.frame_height);
         end
      endcase
   end

endmodule

[src/lpl2x2_line_store.sv]
// ----------------------------------------------------------------------------
// lpl2x2_line_store: one-row pixel memory
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module lpl2x2_line_store #(
   parameter int DEPTH     = lpl2x2_pkg::MAX_WIDTH_DEF,
   parameter int DATA_BITS = lpl2x2_pkg::PIXEL_W
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_BITS-1:0]       wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr_b,
   output logic [DATA_BITS-1:0]       rd_data_a,
   output logic [DATA_BITS-1:0]       rd_data_b
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_a_ff;
   logic [DATA_BITS-1:0] rd_data_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read ports
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule
